>>> rtl/cdq_pkg.sv
// Shared constants and control types for the circular deque unit.
package cdq_pkg;

    localparam int CMD_W    = 3;
    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic finish;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_read;
    } ctrl_sts_t;

endpackage

>>> rtl/cdq_cmd_if.sv
// Request channel of the circular deque unit.
interface cdq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [cdq_pkg::CMD_W-1:0]   command;
    logic [cdq_pkg::FIELD_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

>>> rtl/cdq_rsp_if.sv
// Result channel of the circular deque unit.
interface cdq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cdq_pkg::FIELD_W-1:0]  popped_value;
    logic [cdq_pkg::FIELD_W-1:0]  front_value;
    logic [cdq_pkg::FIELD_W-1:0]  back_value;
    logic [cdq_pkg::COUNT_W-1:0]  count;
    logic [cdq_pkg::STATUS_W-1:0] status;

    modport source (output valid, output popped_value, output front_value,
                    output back_value, output count, output status, input ready);
    modport sink (input valid, input popped_value, input front_value,
                  input back_value, input count, input status, output ready);
endinterface

>>> rtl/cdq_datapath.sv
// Deque datapath: slot memory, pointers, cached front/back and result register.
module cdq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdq_pkg::ctrl_cmd_t            ctl,
    output cdq_pkg::ctrl_sts_t            sts,
    input  logic [cdq_pkg::CMD_W-1:0]     command,
    input  logic [cdq_pkg::FIELD_W-1:0]   value,
    output logic [cdq_pkg::FIELD_W-1:0]   popped_value,
    output logic [cdq_pkg::FIELD_W-1:0]   front_value,
    output logic [cdq_pkg::FIELD_W-1:0]   back_value,
    output logic [cdq_pkg::COUNT_W-1:0]   count,
    output logic [cdq_pkg::STATUS_W-1:0]  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int FW    = cdq_pkg::FIELD_W;
    localparam int CW    = cdq_pkg::COUNT_W;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] i);
        return (i == '0) ? LAST : i - 1'b1;
    endfunction

    logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;
    logic                  pend_back_reg, pend_back_next;
    logic [DATA_WIDTH-1:0] pend_popped_reg, pend_popped_next;

    logic [FW-1:0]                 out_popped_reg;
    logic [FW-1:0]                 out_front_reg;
    logic [FW-1:0]                 out_back_reg;
    logic [CW-1:0]                 out_count_reg;
    logic [cdq_pkg::STATUS_W-1:0]  out_status_reg;

    logic [DATA_WIDTH-1:0]         val_w;
    logic [DATA_WIDTH-1:0]         popped_next;
    logic [cdq_pkg::STATUS_W-1:0]  status_next;
    logic                          empty, full;
    logic                          wr_en, rd_en;
    logic [PTR_W-1:0]              wr_addr, rd_addr;
    logic [PTR_W-1:0]              head_inc, head_dec, tail_inc, tail_dec;

    assign val_w    = DATA_WIDTH'(value);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL);
    assign head_inc = ring_inc(head_reg);
    assign head_dec = ring_dec(head_reg);
    assign tail_inc = ring_inc(tail_reg);
    assign tail_dec = ring_dec(tail_reg);

    // A successful pop has to fetch the new front or back from the slot memory
    assign sts.needs_read = !empty &&
        ((command == cdq_pkg::CMD_POP_BACK) || (command == cdq_pkg::CMD_POP_FRONT));

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        pend_back_next   = pend_back_reg;
        pend_popped_next = pend_popped_reg;
        popped_next      = '0;
        status_next      = cdq_pkg::ST_OK;
        wr_en            = 1'b0;
        wr_addr          = head_reg;
        rd_en            = 1'b0;
        rd_addr          = tail_dec;
        if (ctl.accept)
        begin
            unique case (command)
                cdq_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = cdq_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        tail_next  = tail_inc;
                        wr_en      = 1'b1;
                        wr_addr    = tail_inc;
                        count_next = count_reg + 1'b1;
                        back_next  = val_w;
                        if (empty)
                        begin
                            front_next = val_w;
                        end
                    end
                end
                cdq_pkg::CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = cdq_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        wr_en      = 1'b1;
                        wr_addr    = head_reg;
                        count_next = count_reg + 1'b1;
                        front_next = val_w;
                        if (empty)
                        begin
                            back_next = val_w;
                        end
                    end
                end
                cdq_pkg::CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        tail_next        = tail_dec;
                        count_next       = count_reg - 1'b1;
                        rd_en            = 1'b1;
                        rd_addr          = tail_dec;
                        pend_back_next   = 1'b1;
                        pend_popped_next = back_reg;
                    end
                end
                cdq_pkg::CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        head_next        = head_inc;
                        count_next       = count_reg - 1'b1;
                        rd_en            = 1'b1;
                        rd_addr          = ring_inc(head_inc);
                        pend_back_next   = 1'b0;
                        pend_popped_next = front_reg;
                    end
                end
                cdq_pkg::CMD_CLEAR:
                begin
                    if (empty)
                    begin
                        status_next = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                end
                default:
                begin
                    // query and unused codes leave the state alone
                end
            endcase
        end
        else if (ctl.finish)
        begin
            popped_next = pend_popped_reg;
            if (pend_back_reg)
            begin
                back_next = rd_data_reg;
            end
            else
            begin
                front_next = rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= val_w;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg       <= front_next;
        back_reg        <= back_next;
        pend_back_reg   <= pend_back_next;
        pend_popped_reg <= pend_popped_next;
        if (ctl.load_out)
        begin
            out_popped_reg <= FW'(popped_next);
            out_front_reg  <= (count_next == '0) ? '0 : FW'(front_next);
            out_back_reg   <= (count_next == '0) ? '0 : FW'(back_next);
            out_count_reg  <= CW'(count_next);
            out_status_reg <= status_next;
        end
    end

    assign popped_value = out_popped_reg;
    assign front_value  = out_front_reg;
    assign back_value   = out_back_reg;
    assign count        = out_count_reg;
    assign status       = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("element count above depth");
`endif

endmodule

>>> rtl/cdq_ctrl.sv
// Deque controller: request acceptance, memory read wait and result valid.
module cdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cdq_pkg::ctrl_sts_t sts,
    output cdq_pkg::ctrl_cmd_t ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // A new request may enter once the result register is free or being drained
    assign in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign ctl.accept   = in_valid && in_ready;
    assign ctl.finish   = (state_reg == S_READ);
    assign ctl.load_out = (ctl.accept && !sts.needs_read) || ctl.finish;
    assign out_valid    = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.accept && sts.needs_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_IDLE && out_valid_reg)
        else $error("read wait did not complete in one cycle");

    a_pop_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept && sts.needs_read |=> state_reg == S_READ && !out_valid_reg)
        else $error("pop did not wait for slot read");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !ctl.load_out)
        else $error("result overwritten while stalled");
`endif

endmodule

>>> rtl/circular_double_ended_queue_unit.sv
// Top level of the circular deque unit.
//
// Requests enter on cmd (command, value) and each gives exactly one result on
// rsp: popped value, front and back after the step, element count and status.
// Push back/front, clear and query are done in the accept cycle; the result is
// registered and shows on rsp in the next cycle. A successful pop also reads the
// new front or back from the slot memory (single read port, registered data),
// so its result passes the read data register, then the result register.
// One request per cycle unless rsp stalls or a successful pop is in its read.
// Push on a full deque returns status overflow, pop or clear on an empty one
// returns status underflow; neither changes the contents.
// Reset empties the deque at once (pointers and count to zero); the slot
// memory is not cleared, since a slot holding no element never reaches rsp.
// When rsp stalls the result is held and one further request may be taken
// the same cycle the held result drains; otherwise cmd.ready stays low.
module circular_double_ended_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    cdq_cmd_if.sink   cmd,
    cdq_rsp_if.source rsp
);

    cdq_pkg::ctrl_cmd_t ctl;
    cdq_pkg::ctrl_sts_t sts;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .command      (cmd.command),
        .value        (cmd.value),
        .popped_value (rsp.popped_value),
        .front_value  (rsp.front_value),
        .back_value   (rsp.back_value),
        .count        (rsp.count),
        .status       (rsp.status)
    );

endmodule
